// ----- rtl/ihds_pkg.sv -----
// Package for the image header dimension sniffer: payload types, codes, constants.
package ihds_pkg;
  localparam int HeaderBytes   = 32;
  localparam int JpegStepLimit = 2000;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOTGIF  = 3'd2;
  localparam logic [2:0] ST_LARGE   = 3'd3;
  localparam logic [2:0] ST_UNSUP   = 3'd4;

  localparam logic [2:0] FMT_GIF  = 3'd0;
  localparam logic [2:0] FMT_PNG  = 3'd1;
  localparam logic [2:0] FMT_JPEG = 3'd2;
  localparam logic [2:0] FMT_WEBP = 3'd3;
  localparam logic [2:0] FMT_NONE = 3'd4;

  localparam logic [1:0] REG_CHECK_MODE     = 2'd0;
  localparam logic [1:0] REG_MAX_DIMENSION  = 2'd1;
  localparam logic [1:0] REG_MAX_FILE_BYTES = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  status;
    logic [2:0]  format_code;
    logic [24:0] image_width;
    logic [24:0] image_height;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;
endpackage

// ----- rtl/image_header_dimension_sniffer.sv -----
// Top level of the image header dimension sniffer.
//   channel | signals                      | payload
//   in      | in_valid, in_ready, in_item   | data_byte, last_byte
//   out     | out_valid, out_ready, out_item| accepted, status, format, width, height
//   cfg     | cfg_valid, cfg_ready, cfg_item| register index, write data
// One byte per cycle unless stalled. Each byte updates the counter, header store and
// JPEG walker; the final byte is evaluated in a second stage (registered snapshot),
// and the result is then registered at the output. A held result stalls input only
// when a second result is ready behind it. Sync reset clears control state.
module image_header_dimension_sniffer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihds_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ihds_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ihds_pkg::cfg_item_t cfg_item
);
  import ihds_pkg::*;

  typedef enum logic [3:0] {
    PH_SEEK, PH_MARK, PH_LENH, PH_LENL, PH_SKIP, PH_PREC,
    PH_H1, PH_H2, PH_W1, PH_W2, PH_DONE
  } phase_t;
  typedef enum logic [1:0] {DIMS_NONE, DIMS_FOUND, DIMS_STOP} dims_t;

  logic        check_mode;
  logic [24:0] max_dimension;
  logic [31:0] max_file_bytes;

  logic [31:0] byte_count;
  logic [7:0]  header_store [HeaderBytes];
  phase_t      jpeg_phase;
  logic [7:0]  jpeg_marker;
  logic [15:0] segment_remaining;
  logic [10:0] walk_steps;
  logic [15:0] found_width, found_height;
  dims_t       dims_found;

  // evaluation stage snapshot
  logic        eval_valid;
  logic [31:0] eval_count;
  logic [7:0]  eval_hdr [HeaderBytes];
  logic [15:0] eval_jw, eval_jh;
  dims_t       eval_dims;

  logic      in_fire, eval_adv;
  out_item_t res, res_next;

  assign cfg_ready = 1'b1;
  assign eval_adv  = eval_valid && (!out_valid || out_ready);
  assign in_ready  = !eval_valid || !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_item  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode     <= 1'b0;
      max_dimension  <= 25'd4096;
      max_file_bytes <= 32'd16777216;
    end else if (cfg_valid) begin
      unique case (cfg_item.index)
        REG_CHECK_MODE:     check_mode     <= cfg_item.data[0];
        REG_MAX_DIMENSION:  max_dimension  <= cfg_item.data[24:0];
        REG_MAX_FILE_BYTES: max_file_bytes <= cfg_item.data;
        default: ;
      endcase
    end
  end

  // next values of the per-byte state
  logic [31:0] cnt_next;
  phase_t      ph_next;
  logic [7:0]  mk_next;
  logic [15:0] seg_next, fw_next, fh_next, len;
  logic [10:0] ws_next;
  dims_t       dims_next;
  logic [7:0]  b;

  always_comb begin
    b         = in_item.data_byte;
    cnt_next  = (byte_count == 32'hFFFF_FFFF) ? byte_count : byte_count + 32'd1;
    ph_next   = jpeg_phase;
    mk_next   = jpeg_marker;
    seg_next  = segment_remaining;
    ws_next   = walk_steps;
    fw_next   = found_width;
    fh_next   = found_height;
    dims_next = dims_found;
    len       = {segment_remaining[15:8], b};
    if (byte_count >= 32'd2) begin
      case (jpeg_phase)
        PH_SEEK: begin
          if (walk_steps >= 11'(JpegStepLimit)) begin
            ph_next = PH_DONE; dims_next = DIMS_STOP;
          end else if (b == 8'hFF) begin
            ph_next = PH_MARK;
          end else begin
            ws_next = walk_steps + 11'd1;
          end
        end
        PH_MARK: begin
          ws_next = walk_steps + 11'd1;
          mk_next = b;
          if (b == 8'hD8 || b == 8'hD9 || b == 8'h01 || b[7:3] == 5'b11010)
            ph_next = PH_SEEK;
          else
            ph_next = PH_LENH;
        end
        PH_LENH: begin
          seg_next = {b, 8'h00}; ph_next = PH_LENL;
        end
        PH_LENL: begin
          if (len < 16'd2) begin
            ph_next = PH_DONE; dims_next = DIMS_STOP;
          end else if (jpeg_marker[7:4] == 4'hC && jpeg_marker != 8'hC4 &&
                       jpeg_marker != 8'hC8 && jpeg_marker != 8'hCC) begin
            ph_next = PH_PREC;
          end else if (jpeg_marker == 8'hDA) begin
            ph_next = PH_DONE; dims_next = DIMS_STOP;
          end else begin
            seg_next = len - 16'd2;
            ph_next  = (len == 16'd2) ? PH_SEEK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          seg_next = segment_remaining - 16'd1;
          if (segment_remaining == 16'd1) ph_next = PH_SEEK;
        end
        PH_PREC: ph_next = PH_H1;
        PH_H1:   begin fh_next = {b, 8'h00}; ph_next = PH_H2; end
        PH_H2:   begin fh_next = {found_height[15:8], b}; ph_next = PH_W1; end
        PH_W1:   begin fw_next = {b, 8'h00}; ph_next = PH_W2; end
        PH_W2:   begin
          fw_next = {found_width[15:8], b}; ph_next = PH_DONE; dims_next = DIMS_FOUND;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0; jpeg_phase <= PH_SEEK; jpeg_marker <= '0;
      segment_remaining <= '0; walk_steps <= '0; found_width <= '0;
      found_height <= '0; dims_found <= DIMS_NONE;
    end else if (in_fire) begin
      if (in_item.last_byte) begin
        byte_count <= '0; jpeg_phase <= PH_SEEK; jpeg_marker <= '0;
        segment_remaining <= '0; walk_steps <= '0; found_width <= '0;
        found_height <= '0; dims_found <= DIMS_NONE;
      end else begin
        byte_count <= cnt_next; jpeg_phase <= ph_next; jpeg_marker <= mk_next;
        segment_remaining <= seg_next; walk_steps <= ws_next;
        found_width <= fw_next; found_height <= fh_next; dims_found <= dims_next;
      end
    end
  end

  // header store: eval snapshot takes the store plus the final byte
  always_ff @(posedge clk) begin
    if (in_fire && byte_count < 32'(HeaderBytes))
      header_store[byte_count[4:0]] <= b;
    if (in_fire && in_item.last_byte) begin
      for (int i = 0; i < HeaderBytes; i++)
        eval_hdr[i] <= (byte_count == 32'(i)) ? b : header_store[i];
      eval_count <= cnt_next;
      eval_jw    <= fw_next;
      eval_jh    <= fh_next;
      eval_dims  <= dims_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) eval_valid <= 1'b0;
    else if (in_fire && in_item.last_byte) eval_valid <= 1'b1;
    else if (eval_adv) eval_valid <= 1'b0;
  end

  // final evaluation
  logic        gifm, pngm, jpgm, webm;
  logic [31:0] w, h, v;
  logic [2:0]  st, fmt;
  logic [31:0] n;
  logic [7:0]  hd [HeaderBytes];

  always_comb begin
    hd  = eval_hdr;
    n   = eval_count;
    st  = ST_OK; fmt = FMT_NONE; w = '0; h = '0;
    v   = {hd[24], hd[23], hd[22], hd[21]};
    gifm = n >= 32'd6 && hd[0] == "G" && hd[1] == "I" && hd[2] == "F" && hd[3] == "8" &&
           (hd[4] == "7" || hd[4] == "9") && hd[5] == "a";
    pngm = n >= 32'd8 && hd[0] == 8'h89 && hd[1] == "P" && hd[2] == "N" && hd[3] == "G" &&
           hd[4] == 8'h0D && hd[5] == 8'h0A && hd[6] == 8'h1A && hd[7] == 8'h0A;
    jpgm = n >= 32'd3 && hd[0] == 8'hFF && hd[1] == 8'hD8 && hd[2] == 8'hFF;
    webm = n >= 32'd12 && hd[0] == "R" && hd[1] == "I" && hd[2] == "F" && hd[3] == "F" &&
           hd[8] == "W" && hd[9] == "E" && hd[10] == "B" && hd[11] == "P";
    if (check_mode || gifm) begin
      fmt = FMT_GIF;
      if (n < 32'd10) st = ST_INVALID;
      else if (!gifm) st = ST_NOTGIF;
      else begin
        w = {16'd0, hd[7], hd[6]};
        h = {16'd0, hd[9], hd[8]};
        if (w == 0 || h == 0) st = ST_INVALID;
      end
    end else if (pngm) begin
      fmt = FMT_PNG;
      w = {hd[16], hd[17], hd[18], hd[19]};
      h = {hd[20], hd[21], hd[22], hd[23]};
      if (n < 32'd24 || !(hd[12] == "I" && hd[13] == "H" && hd[14] == "D" && hd[15] == "R")
          || w == 0 || h == 0 || w[31] || h[31])
        st = ST_INVALID;
    end else if (jpgm) begin
      fmt = FMT_JPEG;
      w = {16'd0, eval_jw};
      h = {16'd0, eval_jh};
      if (n < 32'd4 || eval_dims != DIMS_FOUND || w == 0 || h == 0) st = ST_INVALID;
    end else if (webm) begin
      fmt = FMT_WEBP;
      st  = ST_INVALID;
      if (n < 32'd20) begin
      end else if (hd[12] == "V" && hd[13] == "P" && hd[14] == "8" && hd[15] == "X") begin
        if (n >= 32'd30) begin
          w = {8'd0, hd[26], hd[25], hd[24]} + 32'd1;
          h = {8'd0, hd[29], hd[28], hd[27]} + 32'd1;
          st = ST_OK;
        end
      end else if (hd[12] == "V" && hd[13] == "P" && hd[14] == "8" && hd[15] == "L") begin
        if (n >= 32'd25 && hd[20] == 8'h2F) begin
          w = {18'd0, v[13:0]} + 32'd1;
          h = {18'd0, v[27:14]} + 32'd1;
          st = ST_OK;
        end
      end else if (hd[12] == "V" && hd[13] == "P" && hd[14] == "8" && hd[15] == " ") begin
        if (n >= 32'd30 && hd[23] == 8'h9D && hd[24] == 8'h01 && hd[25] == 8'h2A) begin
          w = {18'd0, hd[27][5:0], hd[26]};
          h = {18'd0, hd[29][5:0], hd[28]};
          if (w != 0 && h != 0) st = ST_OK;
        end
      end
    end else begin
      st = ST_UNSUP;
    end
    if (st == ST_OK && (w > {7'd0, max_dimension} || h > {7'd0, max_dimension} ||
                        n > max_file_bytes))
      st = ST_LARGE;
    if (st != ST_OK) begin
      fmt = FMT_NONE; w = '0; h = '0;
    end
    res_next.accepted     = (st == ST_OK);
    res_next.status       = st;
    res_next.format_code  = fmt;
    res_next.image_width  = w[24:0];
    res_next.image_height = h[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (eval_adv) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (eval_adv) res <= res_next;
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && eval_valid |-> !in_ready)
    else $error("input taken with both result stages full");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.accepted == (out_item.status == ST_OK)))
    else $error("accepted flag disagrees with status");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.accepted |->
      out_item.format_code == FMT_NONE && out_item.image_width == '0)
    else $error("rejected result carries format or size");
  assert property (@(posedge clk) disable iff (rst)
    in_fire && in_item.last_byte |=> eval_valid && byte_count == '0)
    else $error("final byte not handed to evaluation");
endmodule

// ----- verif/image_header_dimension_sniffer_tb.sv -----
// Testbench for the image header dimension sniffer: file stimulus, predictor and result check.
module image_header_dimension_sniffer_tb;
  import ihds_pkg::*;

  localparam int IdleLimit = 6000;

  typedef enum logic [3:0] {
    W_SEEK, W_MARK, W_LENH, W_LENL, W_SKIP, W_PREC, W_H1, W_H2, W_W1, W_W2, W_DONE
  } walk_e;
  typedef enum logic [1:0] {DIMS_NONE, DIMS_FOUND, DIMS_STOP} dims_e;
  typedef enum int {
    K_GIF, K_PNG, K_JPEG, K_VP8X, K_VP8L, K_VP8, K_NOISE, K_JPEG_LONG, K_JPEG_NEAR
  } file_kind_e;

  class sniff_board;
    bit          gif_only;
    logic [24:0] dim_limit;
    logic [31:0] size_limit;
    logic [31:0] count;
    logic [7:0]  head [HeaderBytes];
    walk_e       walk;
    logic [7:0]  marker;
    logic [15:0] seg_left;
    int          steps;
    logic [31:0] fw, fh;
    dims_e       dims;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      gif_only = 0;
      dim_limit = 25'd4096;
      size_limit = 32'd16777216;
      errors = 0;
      clear_file();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_CHECK_MODE: gif_only = val[0];
        REG_MAX_DIMENSION: dim_limit = val[24:0];
        REG_MAX_FILE_BYTES: size_limit = val;
        default: ;
      endcase
    endfunction

    function void clear_file();
      count = 0;
      foreach (head[i]) head[i] = 8'h00;
      walk = W_SEEK;
      marker = 0;
      seg_left = 0;
      steps = 0;
      fw = 0;
      fh = 0;
      dims = DIMS_NONE;
    endfunction

    function int unsigned hb(int unsigned i);
      return i < HeaderBytes ? {24'd0, head[i]} : 0;
    endfunction

    function bit hmatch(int unsigned at, string pat);
      for (int i = 0; i < pat.len(); i++)
        if (hb(at + i) != {24'd0, pat[i]}) return 0;
      return 1;
    endfunction

    function void walk_stop();
      walk = W_DONE;
      dims = DIMS_STOP;
    endfunction

    function void walk_byte(logic [7:0] b);
      int unsigned len;
      case (walk)
        W_SEEK: begin
          if (steps >= JpegStepLimit) begin
            walk_stop();
          end else if (b == 8'hFF) begin
            walk = W_MARK;
          end else begin
            steps++;
          end
        end
        W_MARK: begin
          steps++;
          marker = b;
          if (b == 8'hD8 || b == 8'hD9 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7))
            walk = W_SEEK;
          else
            walk = W_LENH;
        end
        W_LENH: begin
          seg_left = {b, 8'h00};
          walk = W_LENL;
        end
        W_LENL: begin
          len = {16'd0, seg_left} | {24'd0, b};
          if (len < 2) begin
            walk_stop();
          end else if (marker >= 8'hC0 && marker <= 8'hCF && marker != 8'hC4 &&
                       marker != 8'hC8 && marker != 8'hCC) begin
            walk = W_PREC;
          end else if (marker == 8'hDA) begin
            walk_stop();
          end else begin
            seg_left = len[15:0] - 16'd2;
            walk = seg_left == 0 ? W_SEEK : W_SKIP;
          end
        end
        W_SKIP: begin
          seg_left = seg_left - 16'd1;
          if (seg_left == 0) walk = W_SEEK;
        end
        W_PREC: walk = W_H1;
        W_H1: begin
          fh = {16'd0, b, 8'd0};
          walk = W_H2;
        end
        W_H2: begin
          fh = fh | {24'd0, b};
          walk = W_W1;
        end
        W_W1: begin
          fw = {16'd0, b, 8'd0};
          walk = W_W2;
        end
        W_W2: begin
          fw = fw | {24'd0, b};
          walk = W_DONE;
          dims = DIMS_FOUND;
        end
        default: ;
      endcase
    endfunction

    function out_item_t evaluate();
      int unsigned n, w, h, v;
      logic [2:0] st, fmt;
      bit gifm;
      out_item_t r;
      n = count;
      st = ST_OK;
      fmt = FMT_NONE;
      w = 0;
      h = 0;
      gifm = n >= 6 && (hmatch(0, "GIF87a") || hmatch(0, "GIF89a"));
      if (gif_only || gifm) begin
        fmt = FMT_GIF;
        if (n < 10) st = ST_INVALID;
        else if (!gifm) st = ST_NOTGIF;
        else begin
          w = hb(6) | (hb(7) << 8);
          h = hb(8) | (hb(9) << 8);
          if (w == 0 || h == 0) st = ST_INVALID;
        end
      end else if (n >= 8 && hmatch(0, "\211PNG\015\n\032\n")) begin
        fmt = FMT_PNG;
        w = (hb(16) << 24) | (hb(17) << 16) | (hb(18) << 8) | hb(19);
        h = (hb(20) << 24) | (hb(21) << 16) | (hb(22) << 8) | hb(23);
        if (n < 24 || !hmatch(12, "IHDR") || w == 0 || h == 0 || w[31] || h[31])
          st = ST_INVALID;
      end else if (n >= 3 && hb(0) == 8'hFF && hb(1) == 8'hD8 && hb(2) == 8'hFF) begin
        fmt = FMT_JPEG;
        w = fw;
        h = fh;
        if (n < 4 || dims != DIMS_FOUND || w == 0 || h == 0) st = ST_INVALID;
      end else if (n >= 12 && hmatch(0, "RIFF") && hmatch(8, "WEBP")) begin
        fmt = FMT_WEBP;
        st = ST_INVALID;
        if (n < 20) begin
        end else if (hmatch(12, "VP8X")) begin
          if (n >= 30) begin
            w = (hb(24) | (hb(25) << 8) | (hb(26) << 16)) + 1;
            h = (hb(27) | (hb(28) << 8) | (hb(29) << 16)) + 1;
            st = ST_OK;
          end
        end else if (hmatch(12, "VP8L")) begin
          if (n >= 25 && hb(20) == 8'h2F) begin
            v = hb(21) | (hb(22) << 8) | (hb(23) << 16) | (hb(24) << 24);
            w = (v & 32'h3FFF) + 1;
            h = ((v >> 14) & 32'h3FFF) + 1;
            st = ST_OK;
          end
        end else if (hmatch(12, "VP8 ")) begin
          if (n >= 30 && hb(23) == 8'h9D && hb(24) == 8'h01 && hb(25) == 8'h2A) begin
            w = (hb(26) | (hb(27) << 8)) & 32'h3FFF;
            h = (hb(28) | (hb(29) << 8)) & 32'h3FFF;
            if (w != 0 && h != 0) st = ST_OK;
          end
        end
      end else begin
        st = ST_UNSUP;
      end
      if (st == ST_OK && (w > dim_limit || h > dim_limit || n > size_limit)) st = ST_LARGE;
      if (st != ST_OK) begin
        fmt = FMT_NONE;
        w = 0;
        h = 0;
      end
      r.accepted = st == ST_OK;
      r.status = st;
      r.format_code = fmt;
      r.image_width = w[24:0];
      r.image_height = h[24:0];
      return r;
    endfunction

    function void note_input(in_item_t it);
      if (count < HeaderBytes) head[count] = it.data_byte;
      if (count >= 2) walk_byte(it.data_byte);
      if (count != 32'hFFFF_FFFF) count++;
      if (it.last_byte) begin
        pending_q.push_back(evaluate());
        clear_file();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.accepted !== exp_r.accepted) begin
        $error("accepted: expected %0d, got %0d", exp_r.accepted, got.accepted);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.format_code !== exp_r.format_code) begin
        $error("format_code: expected %0d, got %0d", exp_r.format_code, got.format_code);
        errors++;
      end
      if (got.image_width !== exp_r.image_width) begin
        $error("image_width: expected %0d, got %0d", exp_r.image_width, got.image_width);
        errors++;
      end
      if (got.image_height !== exp_r.image_height) begin
        $error("image_height: expected %0d, got %0d", exp_r.image_height, got.image_height);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_item;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  cfg_item_t cfg_item = '0;

  sniff_board  board = new();
  logic [7:0]  fbytes[$];
  int          idle_cycles = 0;

  image_header_dimension_sniffer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_item(cfg_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_item);
  end

  initial begin
    int stall_left, calm_left, r;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 0;
        stall_left--;
      end else begin
        out_ready <= 1;
        r = $urandom_range(0, 99);
        if (calm_left > 0) calm_left--;
        else if (r < 14) stall_left = $urandom_range(1, 3);
        else if (r < 17) stall_left = $urandom_range(10, 40);
        else if (r == 99) calm_left = 300;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_dim(int unsigned top);
    case ($urandom_range(0, 15))
      0: return 0;
      1: return top;
      2: return $urandom & top;
      3: return $urandom_range(4000, 4200) & top;
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  function automatic void put_le(int unsigned v, int nb);
    for (int i = 0; i < nb; i++) fbytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_be(int unsigned v, int nb);
    for (int i = nb - 1; i >= 0; i--) fbytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) fbytes.push_back(s[i]);
  endfunction

  function automatic void put_noise(int lo, int hi);
    repeat ($urandom_range(lo, hi)) fbytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_jpeg_body();
    int seg_len;
    logic [7:0] sof_codes[13] = '{8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hC7,
                                  8'hC9, 8'hCA, 8'hCB, 8'hCD, 8'hCE, 8'hCF};
    logic [7:0] seg_codes[5] = '{8'hE0, 8'hE1, 8'hDB, 8'hC4, 8'hFE};
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 9))
        0: begin
          fbytes.push_back(8'hFF);
          fbytes.push_back(8'($urandom_range(8'hD0, 8'hD9)));
        end
        1: begin
          fbytes.push_back(8'hFF);
          fbytes.push_back(8'h01);
        end
        2: fbytes.push_back(8'($urandom_range(0, 254)));
        3: begin
          fbytes.push_back(8'hFF);
          fbytes.push_back(8'hDA);
          put_be(8, 2);
          put_noise(0, 4);
        end
        4: begin
          fbytes.push_back(8'hFF);
          fbytes.push_back(8'hE0);
          put_be($urandom_range(0, 1), 2);
        end
        default: begin
          seg_len = $urandom_range(2, 9);
          fbytes.push_back(8'hFF);
          fbytes.push_back(seg_codes[$urandom_range(0, 4)]);
          put_be(seg_len, 2);
          put_noise(seg_len - 2, seg_len - 2);
        end
      endcase
    end
    fbytes.push_back(8'hFF);
    fbytes.push_back(sof_codes[$urandom_range(0, 12)]);
    put_be(17, 2);
    fbytes.push_back(8'h08);
    put_be(pick_dim(16'hFFFF), 2);
    put_be(pick_dim(16'hFFFF), 2);
    put_noise(0, 6);
  endfunction

  function automatic void build_file(file_kind_e k, bit intact);
    int unsigned v;
    fbytes.delete();
    case (k)
      K_GIF: begin
        put_str($urandom_range(0, 1) ? "GIF89a" : "GIF87a");
        put_le(pick_dim(16'hFFFF), 2);
        put_le(pick_dim(16'hFFFF), 2);
        put_noise(0, 10);
      end
      K_PNG: begin
        put_str("\211PNG\015\n\032\n");
        put_be(13, 4);
        put_str("IHDR");
        put_be(pick_dim(32'hFFFF_FFFF), 4);
        put_be(pick_dim(32'hFFFF_FFFF), 4);
        put_noise(0, 12);
      end
      K_JPEG, K_JPEG_LONG, K_JPEG_NEAR: begin
        fbytes.push_back(8'hFF);
        fbytes.push_back(8'hD8);
        if (k == K_JPEG) begin
          put_jpeg_body();
        end else begin
          repeat (k == K_JPEG_LONG ? 2010 : 1990) fbytes.push_back(8'h00);
          fbytes.push_back(8'hFF);
          fbytes.push_back(8'hC0);
          put_be(17, 2);
          fbytes.push_back(8'h08);
          put_be(480, 2);
          put_be(640, 2);
        end
      end
      K_VP8X, K_VP8L, K_VP8: begin
        put_str("RIFF");
        put_noise(4, 4);
        put_str("WEBP");
        if (k == K_VP8X) begin
          put_str("VP8X");
          put_noise(8, 8);
          put_le(pick_dim(24'hFFFFFF), 3);
          put_le(pick_dim(24'hFFFFFF), 3);
        end else if (k == K_VP8L) begin
          put_str("VP8L");
          put_noise(4, 4);
          fbytes.push_back(8'h2F);
          v = pick_dim(14'h3FFF) | (pick_dim(14'h3FFF) << 14) | ($urandom_range(0, 15) << 28);
          put_le(v, 4);
        end else begin
          put_str("VP8 ");
          put_noise(7, 7);
          put_be(24'h9D012A, 3);
          put_le(pick_dim(16'hFFFF), 2);
          put_le(pick_dim(16'hFFFF), 2);
        end
        put_noise(0, 6);
      end
      default: put_noise(1, 40);
    endcase
    if (!intact) begin
      if ($urandom_range(0, 7) == 0)
        fbytes[$urandom_range(0, fbytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0)
        fbytes = fbytes[0 : $urandom_range(0, fbytes.size() - 1)];
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last, int gap);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
  endtask

  task automatic send_file();
    bit calm;
    calm = $urandom_range(0, 3) == 0;
    for (int i = 0; i < fbytes.size(); i++)
      send_byte(fbytes[i], i == fbytes.size() - 1, calm ? 0 : pick_gap());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1;
    cfg_item <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic set_config(bit mode, logic [24:0] dim, logic [31:0] size);
    write_reg(REG_CHECK_MODE, {31'd0, mode});
    write_reg(REG_MAX_DIMENSION, {7'd0, dim});
    write_reg(REG_MAX_FILE_BYTES, size);
  endtask

  initial begin
    file_kind_e directed[7] = '{K_GIF, K_PNG, K_JPEG, K_VP8X, K_VP8L, K_VP8, K_NOISE};
    int phase_bytes, phase_files, r;
    logic [24:0] dim;
    logic [31:0] size;
    repeat (10) @(negedge clk);
    rst <= 0;

    foreach (directed[i]) begin
      build_file(directed[i], 1);
      send_file();
    end

    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: set_config(0, 25'h1000000, 32'hFFFF_FFFF);
        2: set_config(0, 25'd1, 32'd1);
        3: set_config(1, 25'd4096, 32'hFFFF_FFFF);
        4: set_config(0, 25'($urandom_range(1, 700)), 32'($urandom_range(10, 60)));
        5: begin
          dim = 25'($urandom);
          size = $urandom;
          set_config($urandom_range(0, 1), dim == 0 ? 25'd1 : dim, size == 0 ? 32'd1 : size);
        end
        default: set_config(0, 25'd4096, 32'd16777216);
      endcase
      phase_bytes = 0;
      phase_files = 0;
      while (phase_bytes < 100 || phase_files < 4) begin
        r = $urandom_range(0, 99);
        if (r < 20) build_file(K_GIF, 0);
        else if (r < 40) build_file(K_PNG, 0);
        else if (r < 65) build_file(K_JPEG, 0);
        else if (r < 73) build_file(K_VP8X, 0);
        else if (r < 81) build_file(K_VP8L, 0);
        else if (r < 90) build_file(K_VP8, 0);
        else build_file(K_NOISE, 0);
        send_file();
        phase_bytes += fbytes.size();
        phase_files++;
      end
    end

    @(negedge clk);
    in_valid <= 0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
